@@ sv/sbrw_pkg.sv @@
package sbrw_pkg;

	localparam int SBOX_ENTRIES = 16;
	localparam int COL_W        = 4;
	localparam int CNT_W        = 5;
	localparam int WEIGHT_W     = 2;
	localparam int TABLE_W      = 64;
	localparam int REG_IDX_W    = 1;
	localparam int QUEUE_DEPTH  = 2;

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_SBOX_TABLE    = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_ANALYSIS_MODE = 1'b1;

	// Analysis modes
	localparam logic MODE_DIFF = 1'b0;
	localparam logic MODE_LIN  = 1'b1;

	typedef logic [COL_W-1:0]    col_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [WEIGHT_W-1:0] weight_t;

	// Weight class of one column
	typedef struct packed {
		logic    listed;
		weight_t weight;
	} class_t;

	// One classified row handed from front to back
	typedef struct packed {
		logic [SBOX_ENTRIES-1:0]              listed;
		logic [SBOX_ENTRIES-1:0][WEIGHT_W-1:0] weights;
	} row_entry_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_COUNT,
		F_PUSH
	} front_state_t;

	// Map a column count to its weight class
	function automatic class_t count_class(input logic mode, input cnt_t cnt);
		class_t c;
		c.listed = 1'b1;
		c.weight = 2'd0;
		if (mode == MODE_DIFF) begin
			case (cnt)
				5'd16:   c.weight = 2'd0;
				5'd4:    c.weight = 2'd2;
				5'd2:    c.weight = 2'd3;
				default: c.listed = 1'b0;
			endcase
		end else begin
			case (cnt) inside
				5'd0, 5'd16:  c.weight = 2'd0;
				5'd4, 5'd12:  c.weight = 2'd1;
				5'd6, 5'd10:  c.weight = 2'd2;
				default:      c.listed = 1'b0;
			endcase
		end
		if (!c.listed)
			c.weight = 2'd0;
		return c;
	endfunction

endpackage

@@ sv/sbrw_front.sv @@
module sbrw_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sbrw_pkg::TABLE_W-1:0] sbox_table,
	input  logic                         analysis_mode,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  sbrw_pkg::col_t               row_index,
	output logic                         push,
	output sbrw_pkg::row_entry_t         push_entry,
	input  logic                         q_full
);
	import sbrw_pkg::*;

	front_state_t state_q, state_d;
	col_t         row_q;
	col_t         x_q;
	cnt_t         cnt_q [SBOX_ENTRIES];
	logic [SBOX_ENTRIES-1:0] inc;
	logic         accept;
	logic         counting;
	col_t         s_a, s_b, diff;
	logic         mask_par;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE:  if (in_valid) state_d = F_COUNT;
			F_COUNT: if (x_q == col_t'(SBOX_ENTRIES - 1)) state_d = F_PUSH;
			F_PUSH:  if (!q_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = 1'b0;
		counting = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			F_IDLE:  in_ready = 1'b1;
			F_COUNT: counting = 1'b1;
			F_PUSH:  push     = !q_full;
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	// S-box lookups for the current x
	assign s_a      = sbox_table[{x_q, 2'b00} +: COL_W];
	assign s_b      = sbox_table[{x_q ^ row_q, 2'b00} +: COL_W];
	assign diff     = s_a ^ s_b;
	assign mask_par = ^(s_a & row_q);

	// Per-column increment for this x
	always_comb begin
		for (int j = 0; j < SBOX_ENTRIES; j++) begin
			if (analysis_mode == MODE_DIFF)
				inc[j] = (diff == col_t'(j));
			else
				inc[j] = ((^(x_q & col_t'(j))) == mask_par);
		end
	end

	// Column counters, one x per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			row_q <= '0;
			for (int j = 0; j < SBOX_ENTRIES; j++)
				cnt_q[j] <= '0;
		end else if (accept) begin
			x_q   <= '0;
			row_q <= row_index;
			for (int j = 0; j < SBOX_ENTRIES; j++)
				cnt_q[j] <= '0;
		end else if (counting) begin
			x_q <= x_q + col_t'(1);
			for (int j = 0; j < SBOX_ENTRIES; j++)
				cnt_q[j] <= cnt_q[j] + cnt_t'(inc[j]);
		end
	end

	// Classify every column
	always_comb begin
		class_t c;
		for (int j = 0; j < SBOX_ENTRIES; j++) begin
			c = count_class(analysis_mode, cnt_q[j]);
			push_entry.listed[j]  = c.listed;
			push_entry.weights[j] = c.weight;
		end
	end

endmodule

@@ sv/sbrw_queue.sv @@
module sbrw_queue #(
	parameter int DEPTH = sbrw_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sbrw_pkg::row_entry_t push_entry,
	output logic                 full,
	input  logic                 pop,
	output sbrw_pkg::row_entry_t pop_entry,
	output logic                 not_empty
);
	import sbrw_pkg::*;

	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(DEPTH - 1);
	localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

	row_entry_t          mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [COUNT_W-1:0]  count_q;
	logic                do_push, do_pop;

	assign full      = (count_q == COUNT_FULL);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_entry = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + COUNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - COUNT_W'(1);
		end
	end

endmodule

@@ sv/sbrw_back.sv @@
module sbrw_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_not_empty,
	input  sbrw_pkg::row_entry_t q_entry,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sbrw_pkg::col_t       column_value,
	output sbrw_pkg::weight_t    weight,
	output logic                 entry_valid,
	output logic                 last
);
	import sbrw_pkg::*;

	logic                                  busy_q;
	logic [SBOX_ENTRIES-1:0]               mask_q;
	logic [SBOX_ENTRIES-1:0][WEIGHT_W-1:0] wts_q;
	logic                                  out_valid_q;
	col_t                                  col_q;
	weight_t                               wt_q;
	logic                                  ev_q, last_q;

	logic                    advance, emit;
	logic [SBOX_ENTRIES-1:0] wmask [4];
	logic [SBOX_ENTRIES-1:0] sel_mask, sel_onehot, mask_next;
	weight_t                 sel_w;
	col_t                    sel_col;

	assign advance = !out_valid_q || out_ready;
	assign emit    = busy_q && advance;
	assign pop     = !busy_q && q_not_empty;

	// Remaining columns split by weight
	always_comb begin
		for (int w = 0; w < 4; w++)
			for (int j = 0; j < SBOX_ENTRIES; j++)
				wmask[w][j] = mask_q[j] && (wts_q[j] == weight_t'(w));
	end

	// Lowest weight present, then lowest column in it
	always_comb begin
		sel_w    = 2'd3;
		sel_mask = wmask[3];
		for (int w = 2; w >= 0; w--) begin
			if (wmask[w] != '0) begin
				sel_w    = weight_t'(w);
				sel_mask = wmask[w];
			end
		end
		sel_col    = '0;
		sel_onehot = '0;
		for (int j = SBOX_ENTRIES - 1; j >= 0; j--) begin
			if (sel_mask[j]) begin
				sel_col    = col_t'(j);
				sel_onehot = SBOX_ENTRIES'(1) << j;
			end
		end
		mask_next = mask_q & ~sel_onehot;
	end

	// Working row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mask_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			mask_q <= q_entry.listed;
		end else if (emit) begin
			mask_q <= mask_next;
			if (mask_next == '0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			wts_q <= q_entry.weights;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (mask_q == '0) begin
				col_q  <= '0;
				wt_q   <= '0;
				ev_q   <= 1'b0;
				last_q <= 1'b1;
			end else begin
				col_q  <= sel_col;
				wt_q   <= sel_w;
				ev_q   <= 1'b1;
				last_q <= (mask_next == '0);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign column_value = col_q;
	assign weight       = wt_q;
	assign entry_valid  = ev_q;
	assign last         = last_q;

endmodule

@@ sv/sbox_row_weight_order_unit.sv @@
// Classifies one row of a 4-bit S-box analysis table per request and returns the
// listed columns ordered by weight, then by column, with last set on the final
// result (a row with nothing listed returns one result with entry_valid low).
// The front end steps x over the sixteen S-box entries one per cycle, updating
// sixteen column counters in parallel, then hands the classified row to a small
// queue (QUEUE_DEPTH rows), stalling while it is full; it takes no new request
// until that hand-off. The back end emits a row's results one per cycle while
// out_ready is high. Configuration (table and mode) must only be written while no
// request is in flight.
module sbox_row_weight_order_unit #(
	parameter int QUEUE_DEPTH = sbrw_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sbrw_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [sbrw_pkg::TABLE_W-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  sbrw_pkg::col_t                 row_index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output sbrw_pkg::col_t                 column_value,
	output sbrw_pkg::weight_t              weight,
	output logic                           entry_valid,
	output logic                           last
);
	import sbrw_pkg::*;

	logic [TABLE_W-1:0] sbox_table_q;
	logic               analysis_mode_q;
	logic               push, q_full, pop, q_not_empty;
	row_entry_t         push_entry, pop_entry;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbox_table_q    <= '0;
			analysis_mode_q <= MODE_DIFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SBOX_TABLE:    sbox_table_q    <= cfg_data;
				REG_ANALYSIS_MODE: analysis_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sbrw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.sbox_table    (sbox_table_q),
		.analysis_mode (analysis_mode_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.row_index     (row_index),
		.push          (push),
		.push_entry    (push_entry),
		.q_full        (q_full)
	);

	sbrw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.not_empty  (q_not_empty)
	);

	sbrw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_entry      (pop_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.column_value (column_value),
		.weight       (weight),
		.entry_valid  (entry_valid),
		.last         (last)
	);

endmodule

@@ sv/sbrw_checker.sv @@
module sbrw_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input sbrw_pkg::col_t      column_value,
	input sbrw_pkg::weight_t   weight,
	input logic                entry_valid,
	input logic                last
);
	import sbrw_pkg::*;

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(column_value) &&
		$stable(weight) && $stable(entry_valid) && $stable(last))
		else $error("stalled result changed");

	// Front end is busy right after taking a request
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while counting");

	// An empty-row marker always closes its row
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> last)
		else $error("empty-row result without last");

	// An empty-row marker carries zero column and weight
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> column_value == '0 && weight == '0)
		else $error("empty-row result has nonzero payload");

endmodule

bind sbox_row_weight_order_unit sbrw_checker u_sbrw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.column_value (column_value),
	.weight       (weight),
	.entry_valid  (entry_valid),
	.last         (last)
);

@@ sim/sbox_row_weight_order_unit_tb.sv @@
module sbox_row_weight_order_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sbrw_pkg::*;

	// One result of a classified row
	typedef struct packed {
		col_t    column_value;
		weight_t weight;
		logic    entry_valid;
		logic    last;
	} row_result_t;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 40;

	// S-boxes with known row shapes
	localparam logic [TABLE_W-1:0] AND_SBOX     = 64'h1000_1000_1000_1000; // S = x0 & x1
	localparam logic [TABLE_W-1:0] BENT_SBOX    = 64'h0111_1000_1000_1000; // bit 0 bent
	localparam logic [TABLE_W-1:0] INVERT_SBOX  = 64'h0123_4567_89AB_CDEF; // S = ~x
	localparam logic [TABLE_W-1:0] CIPHER_SBOX  = 64'h2174_8FE3_DA09_B65C;
	localparam logic [TABLE_W-1:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index   = REG_SBOX_TABLE;
	logic [TABLE_W-1:0]   cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	col_t                 row_index   = '0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	col_t                 column_value;
	weight_t              weight;
	logic                 entry_valid;
	logic                 last;

	// Copy of the block's registers as last written
	logic [TABLE_W-1:0] sbox_shadow = '0;
	logic               mode_shadow = MODE_DIFF;

	row_result_t pending_columns[$];
	int          mismatch_count = 0;
	int          quiet_cycles   = 0;
	bit          no_idle        = 1'b0;

	sbox_row_weight_order_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.row_index    (row_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.column_value (column_value),
		.weight       (weight),
		.entry_valid  (entry_valid),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Count every column of a row, classify, and queue the ordered results
	function automatic void rank_row_columns(input col_t row);
		int          hits[SBOX_ENTRIES];
		bit          listed[SBOX_ENTRIES];
		weight_t     wclass[SBOX_ENTRIES];
		col_t        xv;
		col_t        cv;
		col_t        sx;
		col_t        sxr;
		int          c;
		int          x;
		int          w;
		int          n_listed;
		int          emitted;
		row_result_t r;
		n_listed = 0;
		for (c = 0; c < SBOX_ENTRIES; c++) begin
			cv      = col_t'(c);
			hits[c] = 0;
			for (x = 0; x < SBOX_ENTRIES; x++) begin
				xv  = col_t'(x);
				sx  = sbox_shadow[4*x +: 4];
				sxr = sbox_shadow[4*(x ^ int'(row)) +: 4];
				if (mode_shadow == MODE_DIFF) begin
					if ((sx ^ sxr) == cv)
						hits[c]++;
				end else if ((^(xv & cv)) == (^(sx & row))) begin
					hits[c]++;
				end
			end
			listed[c] = 1'b1;
			wclass[c] = '0;
			if (mode_shadow == MODE_DIFF) begin
				case (hits[c])
					16:      wclass[c] = 2'd0;
					4:       wclass[c] = 2'd2;
					2:       wclass[c] = 2'd3;
					default: listed[c] = 1'b0;
				endcase
			end else begin
				case (hits[c])
					0, 16:   wclass[c] = 2'd0;
					4, 12:   wclass[c] = 2'd1;
					6, 10:   wclass[c] = 2'd2;
					default: listed[c] = 1'b0;
				endcase
			end
			if (listed[c])
				n_listed++;
		end
		// ascending weight, then ascending column
		emitted = 0;
		for (w = 0; w < 4; w++) begin
			for (c = 0; c < SBOX_ENTRIES; c++) begin
				if (listed[c] && wclass[c] == weight_t'(w)) begin
					r.column_value = col_t'(c);
					r.weight       = weight_t'(w);
					r.entry_valid  = 1'b1;
					r.last         = (emitted == n_listed - 1);
					pending_columns.push_back(r);
					emitted++;
				end
			end
		end
		// nothing listed: one marker result
		if (n_listed == 0) begin
			r.column_value = '0;
			r.weight       = '0;
			r.entry_valid  = 1'b0;
			r.last         = 1'b1;
			pending_columns.push_back(r);
		end
	endfunction

	// Send one request; called and returns at a falling edge
	task automatic send_row(input col_t row);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			if (in_valid)
				in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		row_index <= row;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		rank_row_columns(row);
		@(negedge clk);
	endtask

	// Stop requests and wait for every outstanding result
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_columns.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Write both registers while the block is idle
	task automatic apply_setup(input logic [TABLE_W-1:0] sbox_word,
			input logic [TABLE_W-1:0] mode_word);
		settle_block();
		cfg_we    <= 1'b1;
		cfg_index <= REG_SBOX_TABLE;
		cfg_data  <= sbox_word;
		@(negedge clk);
		cfg_index <= REG_ANALYSIS_MODE;
		cfg_data  <= mode_word;
		@(negedge clk);
		cfg_we      <= 1'b0;
		sbox_shadow = sbox_word;
		mode_shadow = mode_word[0];
	endtask

	// Registers at reset values: zero table, differential
	task automatic test_reset_defaults();
		send_row(4'h0);
		send_row(4'hF);
		send_row(4'h9);
	endtask

	task automatic test_differential_corners();
		// mode word with every upper bit set, bit 0 clear
		apply_setup(ALL_ONES, 64'hFFFF_FFFF_FFFF_FFFE);
		send_row(4'hA);
		// rows 1 and 3 split 8/8: empty rows
		apply_setup(AND_SBOX, 64'h0);
		send_row(4'h1);
		send_row(4'h3);
		send_row(4'h4);
		apply_setup(CIPHER_SBOX, 64'h0);
		send_row(4'h0);
		send_row(4'h1);
		send_row(4'h7);
		send_row(4'hC);
		send_row(4'hF);
	endtask

	task automatic test_linear_corners();
		apply_setup(64'h0, 64'h1);
		send_row(4'h0);
		send_row(4'hF);
		// bent output bit: row 1 lists all sixteen columns
		apply_setup(BENT_SBOX, ALL_ONES);
		send_row(4'h1);
		send_row(4'h0);
		send_row(4'h2);
		// counts of 4 and 12
		apply_setup(AND_SBOX, 64'h1);
		send_row(4'h1);
		// count of zero
		apply_setup(INVERT_SBOX, 64'h1);
		send_row(4'h1);
		apply_setup(CIPHER_SBOX, 64'h1);
		send_row(4'h1);
		send_row(4'h8);
		send_row(4'hF);
	endtask

	// Random tables and modes in phases of random rows
	task automatic test_random_rows();
		col_t               perm[SBOX_ENTRIES];
		col_t               tmp;
		logic [TABLE_W-1:0] sbox_word;
		int                 sent;
		int                 n_rows;
		int                 i;
		int                 j;
		sent = 0;
		while (sent < 128) begin
			if ($urandom_range(0, 1) == 0) begin
				sbox_word = {$urandom, $urandom};
			end else begin
				// random permutation
				for (i = 0; i < SBOX_ENTRIES; i++)
					perm[i] = col_t'(i);
				for (i = SBOX_ENTRIES - 1; i > 0; i--) begin
					j       = $urandom_range(0, i);
					tmp     = perm[i];
					perm[i] = perm[j];
					perm[j] = tmp;
				end
				for (i = 0; i < SBOX_ENTRIES; i++)
					sbox_word[4*i +: 4] = perm[i];
			end
			apply_setup(sbox_word, {$urandom, $urandom});
			no_idle = ($urandom_range(0, 3) == 0);
			n_rows  = $urandom_range(12, 24);
			for (i = 0; i < n_rows; i++) begin
				// now and then hold off until the block is empty
				if ($urandom_range(0, 15) == 0)
					settle_block();
				send_row(col_t'($urandom_range(0, 15)));
				sent++;
			end
		end
		no_idle = 1'b0;
	endtask

	// Result side: random stall before each result
	initial begin : reply_side
		int stall;
		@(negedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		row_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_columns.size() == 0) begin
				$error("unexpected result: column_value %0d weight %0d entry_valid %0d last %0d",
					column_value, weight, entry_valid, last);
				mismatch_count++;
			end else begin
				want = pending_columns.pop_front();
				if (column_value !== want.column_value) begin
					$error("column_value: expected %0d, got %0d", want.column_value, column_value);
					mismatch_count++;
				end
				if (weight !== want.weight) begin
					$error("weight: expected %0d, got %0d", want.weight, weight);
					mismatch_count++;
				end
				if (entry_valid !== want.entry_valid) begin
					$error("entry_valid: expected %0d, got %0d", want.entry_valid, entry_valid);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: too long without any transfer
	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : run
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_differential_corners();
		test_linear_corners();
		test_random_rows();
		settle_block();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_columns.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
sv/sbrw_pkg.sv
sv/sbrw_front.sv
sv/sbrw_queue.sv
sv/sbrw_back.sv
sv/sbox_row_weight_order_unit.sv
sv/sbrw_checker.sv
sim/sbox_row_weight_order_unit_tb.sv
